@@ hw/rtl/ptds_pkg.sv @@
// Package for the point to triangle squared distance block: widths, codes and item types.
`default_nettype none
package ptds_pkg;

  // Coordinate width of the input fields.
  localparam int COORD_BITS = 24;

  // Vertex differences and their products.
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int DOT_W   = PROD_W + 2;
  localparam int HALF_W  = DOT_W / 2;
  // Products of dot products and the barycentric terms.
  localparam int VPROD_W = 2 * DOT_W;
  localparam int V_W     = VPROD_W + 1;
  localparam int DEN_W   = V_W + 2;
  localparam int NHALF_W = DEN_W / 2;
  // Rounded quotient numerator and divisor.
  localparam int NUM_W   = DIFF_W + DEN_W + 1;
  localparam int N_W     = NUM_W + 2;
  localparam int DD_W    = DEN_W + 1;
  localparam int REM_W   = DD_W + 1;
  // Quotient bits: the closest point lies within the triangle's bounding span.
  localparam int QB      = COORD_BITS + 3;
  localparam int Q_W     = QB + 1;
  localparam int DQ_W    = Q_W + 2;
  localparam int SQ_W    = 2 * DQ_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int DIST_W  = 50;
  localparam int SAT_W   = (SUM_W > DIST_W) ? SUM_W : DIST_W + 1;

  // Region codes.
  localparam logic [2:0] REGION_A        = 3'd0;
  localparam logic [2:0] REGION_B        = 3'd1;
  localparam logic [2:0] REGION_AB       = 3'd2;
  localparam logic [2:0] REGION_C        = 3'd3;
  localparam logic [2:0] REGION_AC       = 3'd4;
  localparam logic [2:0] REGION_BC       = 3'd5;
  localparam logic [2:0] REGION_INTERIOR = 3'd6;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
    coord_t vertex_a_x;
    coord_t vertex_a_y;
    coord_t vertex_a_z;
    coord_t vertex_b_x;
    coord_t vertex_b_y;
    coord_t vertex_b_z;
    coord_t vertex_c_x;
    coord_t vertex_c_y;
    coord_t vertex_c_z;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance_squared;
    logic [2:0]        region;
    logic              degenerate;
  } out_item_t;

endpackage
`default_nettype wire

@@ hw/rtl/ptds_in_if.sv @@
// Input channel: one query point and triangle per item.
`default_nettype none
interface ptds_in_if;
  import ptds_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/ptds_out_if.sv @@
// Output channel: squared distance, region and degenerate flag per item.
`default_nettype none
interface ptds_out_if;
  import ptds_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/point_triangle_distance_squared.sv @@
// Top level: pipelined point to triangle squared distance with region classification.
//
//   Channel | Dir | Payload
//   req     | in  | point, vertex A, B, C (12 signed coordinates)
//   rsp     | out | distance_squared, region, degenerate
//
// One item enters per cycle while rsp is not stalled.
// The rounding division is a restoring divider pipelined one quotient bit per stage.
// Reset clears the valid bits only; data registers carry no reset.
// A stall on rsp freezes the whole pipeline, so no item is lost or repeated.
`default_nettype none
module point_triangle_distance_squared (
  input wire logic clk,
  input wire logic rst,
  ptds_in_if.sink  req,
  ptds_out_if.source rsp
);
  import ptds_pkg::*;

  logic en;

  // Stage 1: vertex differences.
  coord_t pv [3];
  coord_t av [3];
  coord_t bv [3];
  coord_t cv [3];
  logic v1;
  logic signed [DIFF_W-1:0] s1_ab [3];
  logic signed [DIFF_W-1:0] s1_ac [3];
  logic signed [DIFF_W-1:0] s1_bc [3];
  logic signed [DIFF_W-1:0] s1_ap [3];
  logic signed [DIFF_W-1:0] s1_bp [3];
  logic signed [DIFF_W-1:0] s1_cp [3];

  assign pv[0] = req.data.point_x;
  assign pv[1] = req.data.point_y;
  assign pv[2] = req.data.point_z;
  assign av[0] = req.data.vertex_a_x;
  assign av[1] = req.data.vertex_a_y;
  assign av[2] = req.data.vertex_a_z;
  assign bv[0] = req.data.vertex_b_x;
  assign bv[1] = req.data.vertex_b_y;
  assign bv[2] = req.data.vertex_b_z;
  assign cv[0] = req.data.vertex_c_x;
  assign cv[1] = req.data.vertex_c_y;
  assign cv[2] = req.data.vertex_c_z;

  // The whole pipeline advances unless the output item is held.
  assign en = !rsp.valid || rsp.ready;
  assign req.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s1_ab[k] <= DIFF_W'(bv[k]) - DIFF_W'(av[k]);
        s1_ac[k] <= DIFF_W'(cv[k]) - DIFF_W'(av[k]);
        s1_bc[k] <= DIFF_W'(cv[k]) - DIFF_W'(bv[k]);
        s1_ap[k] <= DIFF_W'(pv[k]) - DIFF_W'(av[k]);
        s1_bp[k] <= DIFF_W'(pv[k]) - DIFF_W'(bv[k]);
        s1_cp[k] <= DIFF_W'(pv[k]) - DIFF_W'(cv[k]);
      end
    end
  end

  // Stage 2: per-axis products for the six dot products.
  logic v2;
  logic signed [PROD_W-1:0] s2_pr [6][3];
  logic signed [DIFF_W-1:0] s2_ab [3];
  logic signed [DIFF_W-1:0] s2_ac [3];
  logic signed [DIFF_W-1:0] s2_bc [3];
  logic signed [DIFF_W-1:0] s2_ap [3];
  logic signed [DIFF_W-1:0] s2_bp [3];
  logic signed [DIFF_W-1:0] s2_cp [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s2_pr[0][k] <= s1_ab[k] * s1_ap[k];
        s2_pr[1][k] <= s1_ac[k] * s1_ap[k];
        s2_pr[2][k] <= s1_ab[k] * s1_bp[k];
        s2_pr[3][k] <= s1_ac[k] * s1_bp[k];
        s2_pr[4][k] <= s1_ab[k] * s1_cp[k];
        s2_pr[5][k] <= s1_ac[k] * s1_cp[k];
        s2_ab[k] <= s1_ab[k];
        s2_ac[k] <= s1_ac[k];
        s2_bc[k] <= s1_bc[k];
        s2_ap[k] <= s1_ap[k];
        s2_bp[k] <= s1_bp[k];
        s2_cp[k] <= s1_cp[k];
      end
    end
  end

  // Stage 3: dot products d1 to d6 (index 0 to 5).
  logic v3;
  logic signed [DOT_W-1:0]  s3_d [6];
  logic signed [DIFF_W-1:0] s3_ab [3];
  logic signed [DIFF_W-1:0] s3_ac [3];
  logic signed [DIFF_W-1:0] s3_bc [3];
  logic signed [DIFF_W-1:0] s3_ap [3];
  logic signed [DIFF_W-1:0] s3_bp [3];
  logic signed [DIFF_W-1:0] s3_cp [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        s3_d[j] <= DOT_W'(s2_pr[j][0]) + DOT_W'(s2_pr[j][1]) + DOT_W'(s2_pr[j][2]);
      end
      s3_ab <= s2_ab;
      s3_ac <= s2_ac;
      s3_bc <= s2_bc;
      s3_ap <= s2_ap;
      s3_bp <= s2_bp;
      s3_cp <= s2_cp;
    end
  end

  // Stage 4: split partial products for d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4.
  logic signed [DOT_W-1:0] ma [6];
  logic signed [DOT_W-1:0] mb [6];
  logic v4;
  logic signed [DOT_W+HALF_W:0]          s4_pl [6];
  logic signed [2*DOT_W-HALF_W-1:0]      s4_ph [6];
  logic signed [DOT_W-1:0]  s4_d [6];
  logic signed [DIFF_W-1:0] s4_ab [3];
  logic signed [DIFF_W-1:0] s4_ac [3];
  logic signed [DIFF_W-1:0] s4_bc [3];
  logic signed [DIFF_W-1:0] s4_ap [3];
  logic signed [DIFF_W-1:0] s4_bp [3];
  logic signed [DIFF_W-1:0] s4_cp [3];

  assign ma[0] = s3_d[0];
  assign mb[0] = s3_d[3];
  assign ma[1] = s3_d[2];
  assign mb[1] = s3_d[1];
  assign ma[2] = s3_d[4];
  assign mb[2] = s3_d[1];
  assign ma[3] = s3_d[0];
  assign mb[3] = s3_d[5];
  assign ma[4] = s3_d[2];
  assign mb[4] = s3_d[5];
  assign ma[5] = s3_d[4];
  assign mb[5] = s3_d[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int m = 0; m < 6; m++) begin
        s4_pl[m] <= ma[m] * $signed({1'b0, mb[m][HALF_W-1:0]});
        s4_ph[m] <= ma[m] * $signed(mb[m][DOT_W-1:HALF_W]);
      end
      s4_d  <= s3_d;
      s4_ab <= s3_ab;
      s4_ac <= s3_ac;
      s4_bc <= s3_bc;
      s4_ap <= s3_ap;
      s4_bp <= s3_bp;
      s4_cp <= s3_cp;
    end
  end

  // Stage 5: recombine the split products.
  logic v5;
  logic signed [VPROD_W-1:0] s5_vp [6];
  logic signed [DOT_W-1:0]  s5_d [6];
  logic signed [DIFF_W-1:0] s5_ab [3];
  logic signed [DIFF_W-1:0] s5_ac [3];
  logic signed [DIFF_W-1:0] s5_bc [3];
  logic signed [DIFF_W-1:0] s5_ap [3];
  logic signed [DIFF_W-1:0] s5_bp [3];
  logic signed [DIFF_W-1:0] s5_cp [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int m = 0; m < 6; m++) begin
        s5_vp[m] <= (VPROD_W'(s4_ph[m]) <<< HALF_W) + VPROD_W'(s4_pl[m]);
      end
      s5_d  <= s4_d;
      s5_ab <= s4_ab;
      s5_ac <= s4_ac;
      s5_bc <= s4_bc;
      s5_ap <= s4_ap;
      s5_bp <= s4_bp;
      s5_cp <= s4_cp;
    end
  end

  // Stage 6: barycentric terms vc, vb, va.
  logic v6;
  logic signed [V_W-1:0]    s6_vc;
  logic signed [V_W-1:0]    s6_vb;
  logic signed [V_W-1:0]    s6_va;
  logic signed [DOT_W-1:0]  s6_d [6];
  logic signed [DIFF_W-1:0] s6_ab [3];
  logic signed [DIFF_W-1:0] s6_ac [3];
  logic signed [DIFF_W-1:0] s6_bc [3];
  logic signed [DIFF_W-1:0] s6_ap [3];
  logic signed [DIFF_W-1:0] s6_bp [3];
  logic signed [DIFF_W-1:0] s6_cp [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_vc <= V_W'(s5_vp[0]) - V_W'(s5_vp[1]);
      s6_vb <= V_W'(s5_vp[2]) - V_W'(s5_vp[3]);
      s6_va <= V_W'(s5_vp[4]) - V_W'(s5_vp[5]);
      s6_d  <= s5_d;
      s6_ab <= s5_ab;
      s6_ac <= s5_ac;
      s6_bc <= s5_bc;
      s6_ap <= s5_ap;
      s6_bp <= s5_bp;
      s6_cp <= s5_cp;
    end
  end

  // Stage 7: region classification and selection of the closest point terms.
  logic signed [DOT_W:0]    d43;
  logic signed [DOT_W:0]    d56;
  logic signed [DEN_W-1:0]  c_den;
  logic signed [DEN_W-1:0]  c_n1;
  logic signed [DEN_W-1:0]  c_n2;
  logic signed [DIFF_W-1:0] c_e1 [3];
  logic signed [DIFF_W-1:0] c_e2 [3];
  logic signed [DIFF_W-1:0] c_pb [3];
  logic [2:0]               c_region;
  logic                     c_degen;
  logic                     c_param;

  always_comb begin
    d43 = (DOT_W+1)'(s6_d[3]) - (DOT_W+1)'(s6_d[2]);
    d56 = (DOT_W+1)'(s6_d[4]) - (DOT_W+1)'(s6_d[5]);
    c_den = DEN_W'(1);
    c_n1 = '0;
    c_n2 = '0;
    c_e1 = s6_ab;
    c_e2 = s6_ac;
    c_pb = s6_ap;
    c_region = REGION_A;
    c_degen = 1'b0;
    c_param = 1'b0;
    if ((s6_d[0][DOT_W-1] || s6_d[0] == '0) && (s6_d[1][DOT_W-1] || s6_d[1] == '0)) begin
      c_region = REGION_A;
    end else if (!s6_d[2][DOT_W-1] && (d43[DOT_W] || d43 == '0)) begin
      c_region = REGION_B;
      c_pb = s6_bp;
    end else if ((s6_vc[V_W-1] || s6_vc == '0) && !s6_d[0][DOT_W-1] &&
                 (s6_d[2][DOT_W-1] || s6_d[2] == '0)) begin
      c_region = REGION_AB;
      c_param = 1'b1;
      c_den = DEN_W'(s6_d[0]) - DEN_W'(s6_d[2]);
      c_n1 = DEN_W'(s6_d[0]);
    end else if (!s6_d[5][DOT_W-1] && (d56[DOT_W] || d56 == '0)) begin
      c_region = REGION_C;
      c_pb = s6_cp;
    end else if ((s6_vb[V_W-1] || s6_vb == '0) && !s6_d[1][DOT_W-1] &&
                 (s6_d[5][DOT_W-1] || s6_d[5] == '0)) begin
      c_region = REGION_AC;
      c_param = 1'b1;
      c_den = DEN_W'(s6_d[1]) - DEN_W'(s6_d[5]);
      c_n1 = DEN_W'(s6_d[1]);
      c_e1 = s6_ac;
    end else if ((s6_va[V_W-1] || s6_va == '0) && !d43[DOT_W] && !d56[DOT_W]) begin
      c_region = REGION_BC;
      c_param = 1'b1;
      c_den = DEN_W'(d43) + DEN_W'(d56);
      c_n1 = DEN_W'(d43);
      c_e1 = s6_bc;
      c_pb = s6_bp;
    end else begin
      c_region = REGION_INTERIOR;
      c_param = 1'b1;
      c_den = DEN_W'(s6_va) + DEN_W'(s6_vb) + DEN_W'(s6_vc);
      c_n1 = DEN_W'(s6_vb);
      c_n2 = DEN_W'(s6_vc);
      // A negative denominator flips all signs; the ratio is unchanged.
      if (c_den[DEN_W-1]) begin
        c_den = -c_den;
        c_n1 = -c_n1;
        c_n2 = -c_n2;
      end
    end
    // A zero denominator falls back to the distance to vertex A.
    if (c_param && c_den == '0) begin
      c_region = REGION_A;
      c_degen = 1'b1;
      c_den = DEN_W'(1);
      c_n1 = '0;
      c_n2 = '0;
      c_pb = s6_ap;
    end
  end

  logic v7;
  logic signed [DEN_W-1:0]  s7_den;
  logic signed [DEN_W-1:0]  s7_n1;
  logic signed [DEN_W-1:0]  s7_n2;
  logic signed [DIFF_W-1:0] s7_e1 [3];
  logic signed [DIFF_W-1:0] s7_e2 [3];
  logic signed [DIFF_W-1:0] s7_pb [3];
  logic [2:0]               s7_region;
  logic                     s7_degen;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_den    <= c_den;
      s7_n1     <= c_n1;
      s7_n2     <= c_n2;
      s7_e1     <= c_e1;
      s7_e2     <= c_e2;
      s7_pb     <= c_pb;
      s7_region <= c_region;
      s7_degen  <= c_degen;
    end
  end

  // Stage 8: split partial products of edge vectors and their weights.
  logic v8;
  logic signed [DIFF_W+NHALF_W:0]        s8_pl1 [3];
  logic signed [DIFF_W+DEN_W-NHALF_W-1:0] s8_ph1 [3];
  logic signed [DIFF_W+NHALF_W:0]        s8_pl2 [3];
  logic signed [DIFF_W+DEN_W-NHALF_W-1:0] s8_ph2 [3];
  logic signed [DEN_W-1:0]  s8_den;
  logic signed [DIFF_W-1:0] s8_pb [3];
  logic [2:0]               s8_region;
  logic                     s8_degen;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (en) begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s8_pl1[k] <= s7_e1[k] * $signed({1'b0, s7_n1[NHALF_W-1:0]});
        s8_ph1[k] <= s7_e1[k] * $signed(s7_n1[DEN_W-1:NHALF_W]);
        s8_pl2[k] <= s7_e2[k] * $signed({1'b0, s7_n2[NHALF_W-1:0]});
        s8_ph2[k] <= s7_e2[k] * $signed(s7_n2[DEN_W-1:NHALF_W]);
      end
      s8_den    <= s7_den;
      s8_pb     <= s7_pb;
      s8_region <= s7_region;
      s8_degen  <= s7_degen;
    end
  end

  // Stage 9: numerators of the closest point offset.
  logic v9;
  logic signed [NUM_W-1:0]  s9_num [3];
  logic signed [DEN_W-1:0]  s9_den;
  logic signed [DIFF_W-1:0] s9_pb [3];
  logic [2:0]               s9_region;
  logic                     s9_degen;

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else if (en) begin
      v9 <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s9_num[k] <= (NUM_W'(s8_ph1[k]) <<< NHALF_W) + NUM_W'(s8_pl1[k]) +
                     (NUM_W'(s8_ph2[k]) <<< NHALF_W) + NUM_W'(s8_pl2[k]);
      end
      s9_den    <= s8_den;
      s9_pb     <= s8_pb;
      s9_region <= s8_region;
      s9_degen  <= s8_degen;
    end
  end

  // Divider pipeline: entry 0 holds the prepared operands, each later entry one more bit.
  logic             dv_v      [QB+1];
  logic [REM_W-1:0] dv_rem    [QB+1][3];
  logic [QB-1:0]    dv_bits   [QB+1][3];
  logic             dv_neg    [QB+1][3];
  logic [DD_W-1:0]  dv_d      [QB+1];
  logic signed [DIFF_W-1:0] dv_pb [QB+1][3];
  logic [2:0]       dv_region [QB+1];
  logic             dv_degen  [QB+1];

  // Rounded floor division: floor((2*num + den) / (2*den)) by magnitude and sign.
  logic signed [N_W-1:0] rn [3];
  logic [N_W-1:0]        rn_abs [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rn[k] = (N_W'(s9_num[k]) <<< 1) + N_W'(s9_den);
      rn_abs[k] = rn[k][N_W-1] ? N_W'(-rn[k]) : N_W'(rn[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= v9;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        dv_rem[0][k]  <= REM_W'(rn_abs[k] >> QB);
        dv_bits[0][k] <= rn_abs[k][QB-1:0];
        dv_neg[0][k]  <= rn[k][N_W-1];
        dv_pb[0][k]   <= s9_pb[k];
      end
      dv_d[0]      <= {s9_den[DEN_W-1:0], 1'b0};
      dv_region[0] <= s9_region;
      dv_degen[0]  <= s9_degen;
    end
  end

  for (genvar i = 0; i < QB; i++) begin : g_div
    logic [REM_W-1:0] trial [3];
    logic             take  [3];

    // One restoring step per lane: shift in a dividend bit, subtract if it fits.
    always_comb begin
      for (int k = 0; k < 3; k++) begin
        trial[k] = {dv_rem[i][k][REM_W-2:0], dv_bits[i][k][QB-1]};
        take[k]  = trial[k] >= REM_W'(dv_d[i]);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[i+1] <= 1'b0;
      end else if (en) begin
        dv_v[i+1] <= dv_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int k = 0; k < 3; k++) begin
          dv_rem[i+1][k]  <= take[k] ? trial[k] - REM_W'(dv_d[i]) : trial[k];
          dv_bits[i+1][k] <= {dv_bits[i][k][QB-2:0], take[k]};
          dv_neg[i+1][k]  <= dv_neg[i][k];
          dv_pb[i+1][k]   <= dv_pb[i][k];
        end
        dv_d[i+1]      <= dv_d[i];
        dv_region[i+1] <= dv_region[i];
        dv_degen[i+1]  <= dv_degen[i];
      end
    end
  end

  // Final stage 1: signed rounded offset and per-axis difference.
  logic [Q_W-1:0]          qmag [3];
  logic signed [Q_W-1:0]   qs [3];
  logic vf1;
  logic signed [DQ_W-1:0]  f1_diff [3];
  logic [2:0]              f1_region;
  logic                    f1_degen;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qmag[k] = {1'b0, dv_bits[QB][k]} + Q_W'(dv_rem[QB][k] != '0);
      qs[k]   = dv_neg[QB][k] ? -$signed(qmag[k]) : $signed({1'b0, dv_bits[QB][k]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vf1 <= 1'b0;
    end else if (en) begin
      vf1 <= dv_v[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        f1_diff[k] <= DQ_W'(dv_pb[QB][k]) - DQ_W'(qs[k]);
      end
      f1_region <= dv_region[QB];
      f1_degen  <= dv_degen[QB];
    end
  end

  // Final stage 2: squares.
  logic vf2;
  logic signed [SQ_W-1:0] f2_sq [3];
  logic [2:0]             f2_region;
  logic                   f2_degen;

  always_ff @(posedge clk) begin
    if (rst) begin
      vf2 <= 1'b0;
    end else if (en) begin
      vf2 <= vf1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        f2_sq[k] <= f1_diff[k] * f1_diff[k];
      end
      f2_region <= f1_region;
      f2_degen  <= f1_degen;
    end
  end

  // Final stage 3: sum and saturate into the output register.
  logic [SAT_W-1:0] dsum;
  logic vo;
  out_item_t out_reg;

  always_comb begin
    dsum = SAT_W'(unsigned'(SUM_W'(f2_sq[0]) + SUM_W'(f2_sq[1]) + SUM_W'(f2_sq[2])));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (en) begin
      vo <= vf2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_reg.distance_squared <= (dsum[SAT_W-1:DIST_W] != '0) ? {DIST_W{1'b1}}
                                                                : dsum[DIST_W-1:0];
      out_reg.region     <= f2_region;
      out_reg.degenerate <= f2_degen;
    end
  end

  assign rsp.valid = vo;
  assign rsp.data  = out_reg;

endmodule
`default_nettype wire
